// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk with reset rst_n; empty when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(name, prop, msg)
`define ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// File: design/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Payload types, mode codes and constants of the alarm clock core.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam logic [2:0]  MODE_TICK       = 3'd0;
  localparam logic [2:0]  MODE_SET_TIME   = 3'd1;
  localparam logic [2:0]  MODE_SET_ALARM  = 3'd2;
  localparam logic [2:0]  MODE_TOGGLE     = 3'd3;
  localparam logic [2:0]  MODE_SNOOZE     = 3'd4;

  localparam logic [15:0] TPS_RESET       = 16'd1000;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] hr_hi;
    logic [7:0] hr_lo;
    logic [7:0] min_hi;
    logic [7:0] min_lo;
    logic [7:0] sec_hi;
    logic [7:0] sec_lo;
    logic [7:0] snooze_minutes;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       alarm_fired;
    logic       time_valid;
    logic       alarm_on;
    logic [5:0] now_hours_bcd;
    logic [6:0] now_minutes_bcd;
    logic [6:0] now_seconds_bcd;
    logic [5:0] alarm_hours_bcd;
    logic [6:0] alarm_minutes_bcd;
    logic [6:0] alarm_seconds_bcd;
  } out_item_t;

endpackage

// File: design/alarm_clock_with_snooze_core.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_snooze_core
// Time-of-day clock with alarm and snooze, reporting times in packed BCD.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer (tick, set time, set alarm, toggle
//           alarm enable, snooze). Digits are checked for 00:00:00..23:59:59.
//   out_* : exactly one result per command, in order, with flags and the
//           current and alarm times after the command.
//   cfg_* : ticks per second; always ready. Write only while the core is idle.
// out_valid rises in the cycle after the input transfer. One command is
// taken per cycle unless the result stalls: the command is decoded and the
// whole state update done between the input port and the single result
// register. A stalled result register holds its item; in_ready stays high
// while the result is being taken in the same cycle, so a command can enter.
// Reset clears the time, alarm, snooze, prescaler and flags and loads
// ticks per second with 1000. Ticks are ignored until the time is set.
// Time is kept as packed BCD; the snooze point is kept in binary h/m/s.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alarm_clock_with_snooze_core
  import acs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  // state
  logic [15:0] tps_r;
  logic [15:0] tick_cnt_r, tick_cnt_nxt;
  logic [5:0]  now_h_r, now_h_nxt;
  logic [6:0]  now_m_r, now_m_nxt;
  logic [6:0]  now_s_r, now_s_nxt;
  logic [5:0]  alm_h_r, alm_h_nxt;
  logic [6:0]  alm_m_r, alm_m_nxt;
  logic [6:0]  alm_s_r, alm_s_nxt;
  logic [4:0]  snz_h_r, snz_h_nxt;
  logic [5:0]  snz_m_r, snz_m_nxt;
  logic [5:0]  snz_s_r, snz_s_nxt;
  logic        time_set_r, time_set_nxt;
  logic        alarm_en_r, alarm_en_nxt;
  logic        snooze_act_r, snooze_act_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  logic        in_fire;
  logic        accepted;
  logic        fired;
  logic        digits_ok;
  logic [15:0] tick_inc;
  logic [5:0]  inc_h;
  logic [6:0]  inc_m;
  logic [6:0]  inc_s;
  logic        s_wrap, m_wrap;
  logic [4:0]  inc_h_bin;
  logic [5:0]  inc_m_bin, inc_s_bin;
  logic [4:0]  now_h_bin;
  logic [5:0]  now_m_bin, now_s_bin;
  logic [2:0]  snz_q;
  logic [7:0]  snz_r8;
  logic [6:0]  snz_m_sum;
  logic        snz_carry;
  logic [4:0]  snz_h_sum;

  assign in_fire   = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // next value of a 00..59 packed BCD counter
  function automatic logic [6:0] bcd60_inc(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'h59) begin
      r = 7'h00;
    end else if (v[3:0] == 4'd9) begin
      r = {v[6:4] + 3'd1, 4'd0};
    end else begin
      r = {v[6:4], v[3:0] + 4'd1};
    end
    return r;
  endfunction

  // packed BCD (tens in [6:4]) to binary
  function automatic logic [6:0] bcd_to_bin(input logic [6:0] v);
    return {1'b0, v[6:4], 3'b000} + {3'b000, v[6:4], 1'b0} + {3'b000, v[3:0]};
  endfunction

  assign digits_ok = (in_data.hr_hi  <= 8'd2) && (in_data.hr_lo  <= 8'd9) &&
                     (in_data.min_hi <= 8'd5) && (in_data.min_lo <= 8'd9) &&
                     (in_data.sec_hi <= 8'd5) && (in_data.sec_lo <= 8'd9) &&
                     !((in_data.hr_hi == 8'd2) && (in_data.hr_lo > 8'd3));

  // one second on from the current time, wrapping at midnight
  assign s_wrap = (now_s_r == 7'h59);
  assign m_wrap = s_wrap && (now_m_r == 7'h59);
  assign inc_s  = bcd60_inc(now_s_r);
  assign inc_m  = s_wrap ? bcd60_inc(now_m_r) : now_m_r;

  always_comb begin
    inc_h = now_h_r;
    if (m_wrap) begin
      if (now_h_r == 6'h23) begin
        inc_h = 6'h00;
      end else if (now_h_r[3:0] == 4'd9) begin
        inc_h = {now_h_r[5:4] + 2'd1, 4'd0};
      end else begin
        inc_h = {now_h_r[5:4], now_h_r[3:0] + 4'd1};
      end
    end
  end

  assign inc_h_bin = 5'(bcd_to_bin({1'b0, inc_h}));
  assign inc_m_bin = 6'(bcd_to_bin(inc_m));
  assign inc_s_bin = 6'(bcd_to_bin(inc_s));
  assign now_h_bin = 5'(bcd_to_bin({1'b0, now_h_r}));
  assign now_m_bin = 6'(bcd_to_bin(now_m_r));
  assign now_s_bin = 6'(bcd_to_bin(now_s_r));
  assign tick_inc  = tick_cnt_r + 16'd1;

  // snooze minutes split into whole hours and leftover minutes
  always_comb begin
    if (in_data.snooze_minutes >= 8'd240) begin
      snz_q  = 3'd4;
      snz_r8 = in_data.snooze_minutes - 8'd240;
    end else if (in_data.snooze_minutes >= 8'd180) begin
      snz_q  = 3'd3;
      snz_r8 = in_data.snooze_minutes - 8'd180;
    end else if (in_data.snooze_minutes >= 8'd120) begin
      snz_q  = 3'd2;
      snz_r8 = in_data.snooze_minutes - 8'd120;
    end else if (in_data.snooze_minutes >= 8'd60) begin
      snz_q  = 3'd1;
      snz_r8 = in_data.snooze_minutes - 8'd60;
    end else begin
      snz_q  = 3'd0;
      snz_r8 = in_data.snooze_minutes;
    end
  end

  assign snz_m_sum = {1'b0, now_m_bin} + {1'b0, snz_r8[5:0]};
  assign snz_carry = (snz_m_sum >= 7'd60);
  assign snz_h_sum = now_h_bin + {2'b00, snz_q} + {4'b0000, snz_carry};

  always_comb begin
    tick_cnt_nxt   = tick_cnt_r;
    now_h_nxt      = now_h_r;
    now_m_nxt      = now_m_r;
    now_s_nxt      = now_s_r;
    alm_h_nxt      = alm_h_r;
    alm_m_nxt      = alm_m_r;
    alm_s_nxt      = alm_s_r;
    snz_h_nxt      = snz_h_r;
    snz_m_nxt      = snz_m_r;
    snz_s_nxt      = snz_s_r;
    time_set_nxt   = time_set_r;
    alarm_en_nxt   = alarm_en_r;
    snooze_act_nxt = snooze_act_r;
    accepted       = 1'b1;
    fired          = 1'b0;

    case (in_data.mode)
      MODE_TICK: begin
        if (time_set_r) begin
          if (tick_inc >= tps_r) begin
            tick_cnt_nxt = 16'd0;
            now_h_nxt    = inc_h;
            now_m_nxt    = inc_m;
            now_s_nxt    = inc_s;
            if (alarm_en_r) begin
              if ({inc_h, inc_m, inc_s} == {alm_h_r, alm_m_r, alm_s_r}) begin
                fired          = 1'b1;
                snooze_act_nxt = 1'b0;
              end else if (snooze_act_r &&
                           ({inc_h_bin, inc_m_bin, inc_s_bin} ==
                            {snz_h_r, snz_m_r, snz_s_r})) begin
                fired          = 1'b1;
                snooze_act_nxt = 1'b0;
              end
            end
          end else begin
            tick_cnt_nxt = tick_inc;
          end
        end
      end
      MODE_SET_TIME: begin
        if (digits_ok) begin
          now_h_nxt    = {in_data.hr_hi[1:0], in_data.hr_lo[3:0]};
          now_m_nxt    = {in_data.min_hi[2:0], in_data.min_lo[3:0]};
          now_s_nxt    = {in_data.sec_hi[2:0], in_data.sec_lo[3:0]};
          time_set_nxt = 1'b1;
        end else begin
          accepted = 1'b0;
        end
      end
      MODE_SET_ALARM: begin
        if (digits_ok) begin
          alm_h_nxt      = {in_data.hr_hi[1:0], in_data.hr_lo[3:0]};
          alm_m_nxt      = {in_data.min_hi[2:0], in_data.min_lo[3:0]};
          alm_s_nxt      = {in_data.sec_hi[2:0], in_data.sec_lo[3:0]};
          snooze_act_nxt = 1'b0;
        end else begin
          accepted = 1'b0;
        end
      end
      MODE_TOGGLE: begin
        alarm_en_nxt = !alarm_en_r;
      end
      MODE_SNOOZE: begin
        snz_h_nxt      = (snz_h_sum >= 5'd24) ? snz_h_sum - 5'd24 : snz_h_sum;
        snz_m_nxt      = snz_carry ? 6'(snz_m_sum - 7'd60) : snz_m_sum[5:0];
        snz_s_nxt      = now_s_bin;
        snooze_act_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_data_nxt.accepted          = accepted;
    out_data_nxt.alarm_fired       = fired;
    out_data_nxt.time_valid        = time_set_nxt;
    out_data_nxt.alarm_on          = alarm_en_nxt;
    out_data_nxt.now_hours_bcd     = now_h_nxt;
    out_data_nxt.now_minutes_bcd   = now_m_nxt;
    out_data_nxt.now_seconds_bcd   = now_s_nxt;
    out_data_nxt.alarm_hours_bcd   = alm_h_nxt;
    out_data_nxt.alarm_minutes_bcd = alm_m_nxt;
    out_data_nxt.alarm_seconds_bcd = alm_s_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= TPS_RESET;
      tick_cnt_r   <= '0;
      now_h_r      <= '0;
      now_m_r      <= '0;
      now_s_r      <= '0;
      alm_h_r      <= '0;
      alm_m_r      <= '0;
      alm_s_r      <= '0;
      snz_h_r      <= '0;
      snz_m_r      <= '0;
      snz_s_r      <= '0;
      time_set_r   <= 1'b0;
      alarm_en_r   <= 1'b0;
      snooze_act_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        tps_r <= cfg_data;
      end
      if (in_fire) begin
        tick_cnt_r   <= tick_cnt_nxt;
        now_h_r      <= now_h_nxt;
        now_m_r      <= now_m_nxt;
        now_s_r      <= now_s_nxt;
        alm_h_r      <= alm_h_nxt;
        alm_m_r      <= alm_m_nxt;
        alm_s_r      <= alm_s_nxt;
        snz_h_r      <= snz_h_nxt;
        snz_m_r      <= snz_m_nxt;
        snz_s_r      <= snz_s_nxt;
        time_set_r   <= time_set_nxt;
        alarm_en_r   <= alarm_en_nxt;
        snooze_act_r <= snooze_act_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `ASSERT_ALWAYS(a_fire_needs_alarm,
    !(out_valid && out_data.alarm_fired) || (out_data.alarm_on && out_data.time_valid),
    "alarm fired while disabled or with time unset")

  `ASSERT_NEXT(a_time_set_sticky, time_set_r, time_set_r,
    "time valid flag dropped")

  `ASSERT_NEXT(a_fire_clears_snooze, in_fire && fired, !snooze_act_r,
    "snooze still armed after the alarm fired")

  `ASSERT_ALWAYS(a_now_in_range,
    (now_h_r[3:0] <= 4'd9) && (now_s_r[6:4] <= 3'd5) && (now_m_r[6:4] <= 3'd5) &&
    (now_h_r <= 6'h23),
    "current time left the 00:00:00 to 23:59:59 range")

endmodule

// File: bench/alarm_clock_with_snooze_core_test.sv
// ----------------------------------------------------------------------------
// alarm_clock_with_snooze_core_test
// Self-checking bench for the alarm clock core. A scoreboard class keeps its
// own copy of the clock, alarm and snooze state, predicts one report per
// command and compares each report transfer field by field. A short
// directed run covers digit checks, the unset clock, midnight wrap, snooze
// and alarm firing and the prescaler extremes. Randomised alarm and snooze
// sequences follow, under several prescaler settings, with random gaps on
// both sides and a long output stall.
// ----------------------------------------------------------------------------
module alarm_clock_with_snooze_core_test;
  import acs_pkg::*;

  localparam int unsigned DAY_SECS    = 86400;
  localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
  localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
  localparam logic [15:0] RATE_MAX    = 16'hFFFF;

  class alarm_scoreboard;
    bit [15:0] ticks_per_sec;
    bit [15:0] tick_cnt;
    bit [16:0] now_sec;
    bit [16:0] alarm_sec;
    bit [16:0] snooze_sec;
    bit        clock_set;
    bit        alarm_en;
    bit        snooze_armed;
    out_item_t expected_reports[$];
    int unsigned errors;

    function new();
      ticks_per_sec = TPS_RESET;
      tick_cnt      = '0;
      now_sec       = '0;
      alarm_sec     = '0;
      snooze_sec    = '0;
      clock_set     = 1'b0;
      alarm_en      = 1'b0;
      snooze_armed  = 1'b0;
      errors        = 0;
    endfunction

    function void set_rate(bit [15:0] v);
      ticks_per_sec = v;
    endfunction

    function bit digits_legal(in_item_t c);
      if (c.hr_hi > 9 || c.hr_lo > 9 || c.min_hi > 9 ||
          c.min_lo > 9 || c.sec_hi > 9 || c.sec_lo > 9)
        return 1'b0;
      if (c.hr_hi > 2) return 1'b0;
      if (c.hr_hi == 2 && c.hr_lo > 3) return 1'b0;
      if (c.min_hi > 5 || c.sec_hi > 5) return 1'b0;
      return 1'b1;
    endfunction

    function bit [16:0] digits_secs(in_item_t c);
      int unsigned h, m, s;
      h = int'(c.hr_hi) * 10 + int'(c.hr_lo);
      m = int'(c.min_hi) * 10 + int'(c.min_lo);
      s = int'(c.sec_hi) * 10 + int'(c.sec_lo);
      return 17'((h * 60 + m) * 60 + s);
    endfunction

    function bit [6:0] to_bcd(int unsigned v);
      return 7'(((v / 10) << 4) | (v % 10));
    endfunction

    // Advance the local copy by one command and queue the report it causes.
    function void take_command(in_item_t c);
      out_item_t   r;
      int unsigned t;
      r = '0;
      r.accepted = 1'b1;
      case (c.mode)
        MODE_TICK: begin
          if (clock_set) begin
            tick_cnt = tick_cnt + 16'd1;
            // a zero rate behaves as one: the compare always passes
            if (tick_cnt >= ticks_per_sec) begin
              tick_cnt = '0;
              now_sec  = (now_sec == 17'(DAY_SECS - 1)) ? '0 : now_sec + 17'd1;
              if (alarm_en && (now_sec == alarm_sec ||
                               (snooze_armed && now_sec == snooze_sec))) begin
                r.alarm_fired = 1'b1;
                snooze_armed  = 1'b0;
              end
            end
          end
        end
        MODE_SET_TIME: begin
          if (digits_legal(c)) begin
            now_sec   = digits_secs(c);
            clock_set = 1'b1;
          end else begin
            r.accepted = 1'b0;
          end
        end
        MODE_SET_ALARM: begin
          if (digits_legal(c)) begin
            alarm_sec    = digits_secs(c);
            snooze_armed = 1'b0;
          end else begin
            r.accepted = 1'b0;
          end
        end
        MODE_TOGGLE: begin
          alarm_en = !alarm_en;
        end
        MODE_SNOOZE: begin
          t = int'(now_sec) + int'(c.snooze_minutes) * 60;
          if (t >= DAY_SECS) t = t - DAY_SECS;
          snooze_sec   = 17'(t);
          snooze_armed = 1'b1;
        end
        default: begin
        end
      endcase
      r.time_valid        = clock_set;
      r.alarm_on          = alarm_en;
      r.now_hours_bcd     = 6'(to_bcd((int'(now_sec) / 3600) % 24));
      r.now_minutes_bcd   = to_bcd((int'(now_sec) / 60) % 60);
      r.now_seconds_bcd   = to_bcd(int'(now_sec) % 60);
      r.alarm_hours_bcd   = 6'(to_bcd((int'(alarm_sec) / 3600) % 24));
      r.alarm_minutes_bcd = to_bcd((int'(alarm_sec) / 60) % 60);
      r.alarm_seconds_bcd = to_bcd(int'(alarm_sec) % 60);
      expected_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_report(out_item_t got);
      out_item_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: report with none expected, expected nothing, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("accepted", 7'(want.accepted), 7'(got.accepted));
      check_field("alarm_fired", 7'(want.alarm_fired), 7'(got.alarm_fired));
      check_field("time_valid", 7'(want.time_valid), 7'(got.time_valid));
      check_field("alarm_on", 7'(want.alarm_on), 7'(got.alarm_on));
      check_field("now_hours_bcd", 7'(want.now_hours_bcd), 7'(got.now_hours_bcd));
      check_field("now_minutes_bcd", want.now_minutes_bcd, got.now_minutes_bcd);
      check_field("now_seconds_bcd", want.now_seconds_bcd, got.now_seconds_bcd);
      check_field("alarm_hours_bcd", 7'(want.alarm_hours_bcd), 7'(got.alarm_hours_bcd));
      check_field("alarm_minutes_bcd", want.alarm_minutes_bcd, got.alarm_minutes_bcd);
      check_field("alarm_seconds_bcd", want.alarm_seconds_bcd, got.alarm_seconds_bcd);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  bit          gaps_on;
  bit          hold_req;
  int          hold_left;
  int unsigned sent_count;
  alarm_scoreboard sb = new();

  alarm_clock_with_snooze_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #(12 * 400000);
    $display("Regression FAIL");
    $finish;
  end

  function automatic in_item_t plain(input logic [2:0] m);
    in_item_t c;
    c      = '0;
    c.mode = m;
    return c;
  endfunction

  function automatic in_item_t at_time(input logic [2:0] m, input int unsigned s);
    in_item_t    c;
    int unsigned h, mi, se;
    c        = plain(m);
    h        = s / 3600;
    mi       = (s / 60) % 60;
    se       = s % 60;
    c.hr_hi  = 8'(h / 10);
    c.hr_lo  = 8'(h % 10);
    c.min_hi = 8'(mi / 10);
    c.min_lo = 8'(mi % 10);
    c.sec_hi = 8'(se / 10);
    c.sec_lo = 8'(se % 10);
    return c;
  endfunction

  function automatic in_item_t snooze_for(input int unsigned m);
    in_item_t c;
    c                = plain(MODE_SNOOZE);
    c.snooze_minutes = 8'(m);
    return c;
  endfunction

  // Any mode, digits either near the legal range or arbitrary bytes.
  function automatic in_item_t noise();
    in_item_t c;
    c.mode = 3'($urandom_range(7));
    if ($urandom_range(1) == 1) begin
      c.hr_hi  = 8'($urandom_range(2));
      c.hr_lo  = 8'($urandom_range(9));
      c.min_hi = 8'($urandom_range(6));
      c.min_lo = 8'($urandom_range(9));
      c.sec_hi = 8'($urandom_range(6));
      c.sec_lo = 8'($urandom_range(9));
    end else begin
      c.hr_hi  = 8'($urandom_range(255));
      c.hr_lo  = 8'($urandom_range(255));
      c.min_hi = 8'($urandom_range(255));
      c.min_lo = 8'($urandom_range(255));
      c.sec_hi = 8'($urandom_range(255));
      c.sec_lo = 8'($urandom_range(255));
    end
    c.snooze_minutes = 8'($urandom_range(255));
    return c;
  endfunction

  // in_valid is left high after a transfer; settle() lowers it, and so may a gap in the next call.
  task automatic send(input in_item_t c);
    while (gaps_on && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_command(c);
    if (c.mode <= MODE_SNOOZE) sent_count++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_reports.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_rate(input logic [15:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_rate(v);
  endtask

  function automatic int unsigned eff_rate();
    return (sb.ticks_per_sec == 0) ? 1 : int'(sb.ticks_per_sec);
  endfunction

  // Set a time, put the alarm a few seconds on and tick up to it.
  task automatic alarm_run();
    int unsigned t, k;
    t = ($urandom_range(4) == 0) ? DAY_SECS - $urandom_range(1, 3)
                                 : $urandom_range(DAY_SECS - 1);
    k = $urandom_range(1, 4);
    send(at_time(MODE_SET_TIME, t));
    send(at_time(MODE_SET_ALARM, (t + k) % DAY_SECS));
    if (!sb.alarm_en && $urandom_range(7) != 0) send(plain(MODE_TOGGLE));
    repeat (k * eff_rate() + $urandom_range(2)) send(plain(MODE_TICK));
  endtask

  // Arm snooze, then step the time back a little so the snooze point comes up
  // soon; the alarm sits half a day away.
  task automatic snooze_run();
    int unsigned t, m, s, k;
    t = $urandom_range(DAY_SECS - 1);
    m = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3);
    k = $urandom_range(1, 4);
    s = (t + 60 * m) % DAY_SECS;
    send(at_time(MODE_SET_ALARM, (t + DAY_SECS / 2) % DAY_SECS));
    send(at_time(MODE_SET_TIME, t));
    send(snooze_for(m));
    send(at_time(MODE_SET_TIME, (s + DAY_SECS - k) % DAY_SECS));
    if (!sb.alarm_en && $urandom_range(7) != 0) send(plain(MODE_TOGGLE));
    repeat (k * eff_rate() + $urandom_range(2)) send(plain(MODE_TICK));
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = sent_count + quota;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 35) alarm_run();
      else if (pick < 55) snooze_run();
      else if (pick < 80) repeat ($urandom_range(1, 8)) send(noise());
      else repeat ($urandom_range(5, 20)) send(plain(MODE_TICK));
    end
  endtask

  // Result side: check each transfer, stall at random or for a long hold.
  initial begin
    out_ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_report(out_data);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 60;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !(gaps_on && $urandom_range(99) < 38);
      end
    end
  end

  initial begin
    in_item_t c;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_data    <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    gaps_on    = 1'b1;
    hold_req   = 1'b0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // clock not yet set: ticks do nothing, the rest still acts
    send(plain(MODE_TICK));
    send(at_time(MODE_SET_ALARM, 5));
    send(plain(MODE_TOGGLE));
    send(snooze_for(0));
    send(plain(MODE_SPARE_LO));
    send(plain(MODE_SPARE_HI));

    // rejected digits
    c = at_time(MODE_SET_TIME, 0);
    c.hr_hi = 8'd2;
    c.hr_lo = 8'd4;
    send(c);
    c = at_time(MODE_SET_TIME, 0);
    c.hr_hi = 8'd3;
    send(c);
    c = at_time(MODE_SET_TIME, 0);
    c.min_hi = 8'd6;
    send(c);
    c = at_time(MODE_SET_ALARM, 0);
    c.sec_hi = 8'd6;
    send(c);
    c = at_time(MODE_SET_ALARM, 0);
    c.sec_lo = 8'hFF;
    send(c);

    // part of a second at the reset rate, then a lower rate ends it at once;
    // snooze fires at midnight, the alarm at 00:00:05
    send(at_time(MODE_SET_TIME, DAY_SECS - 2));
    repeat (4) send(plain(MODE_TICK));
    write_rate(16'd1);
    repeat (7) send(plain(MODE_TICK));

    send(at_time(MODE_SET_TIME, 23 * 3600));
    send(snooze_for(255));
    write_rate(16'd0);
    repeat (2) send(plain(MODE_TICK));
    write_rate(RATE_MAX);
    repeat (2) send(plain(MODE_TICK));

    write_rate(16'd1);
    random_phase(250);
    // no gaps here; the output hold backs the core up against the input
    write_rate(16'd2);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    random_phase(200);
    gaps_on = 1'b1;
    write_rate(16'd0);
    random_phase(150);
    write_rate(16'($urandom_range(1, 3)));
    random_phase(200);

    settle();
    repeat (5) @(posedge clk);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
